// ===== rtl/rx_ring_consumer_top_macros.svh =====
// Assertion macros used by the checker of the receive ring consumer.
`ifndef RX_RING_CONSUMER_TOP_MACROS_SVH
`define RX_RING_CONSUMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RXRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rx ring consumer check failed");

// The consequent must hold in the cycle after the antecedent.
`define RXRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rx ring consumer check failed");

`endif

// ===== rtl/rxrc_pkg.sv =====
package rxrc_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_LOG2  = $clog2(PAGE_BYTES);
    localparam int MAX_RING   = 1024;
    localparam int ALIGN_MAX  = 12;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RING_ENTRIES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_ENTRIES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_DB_KEY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RING_DB_KEY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_AREA_BASE  = 3'd5;

    localparam logic [1:0] ACT_DESC    = 2'd0;
    localparam logic [1:0] ACT_BATCH   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] DESC_BUF_PACKET = 2'd0;

    localparam logic [2:0] RES_NOT_READY = 3'd0;
    localparam logic [2:0] RES_SKIPPED   = 3'd1;
    localparam logic [2:0] RES_PACKET    = 3'd2;
    localparam logic [2:0] RES_OVERRUN   = 3'd3;
    localparam logic [2:0] RES_BUF_WRITE = 3'd4;
    localparam logic [2:0] RES_RING_DB   = 3'd5;
    localparam logic [2:0] RES_BUF_DB    = 3'd6;

    localparam logic [10:0] RST_RING_ENTRIES   = 11'd1024;
    localparam logic [7:0]  RST_BUFFER_ENTRIES = 8'd255;
    localparam logic [3:0]  RST_ALIGN_LOG2     = 4'd6;

    localparam logic [13:0] FILL_MAX  = 14'd16383;
    localparam logic [10:0] BATCH_MAX = 11'd2047;

    typedef struct packed {
        logic [1:0]  action;
        logic        desc_generation;
        logic [1:0]  desc_kind;
        logic        fresh_buffer;
        logic [12:0] payload_bytes;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  entry_index;
        logic [12:0] byte_offset;
        logic [11:0] byte_count;
        logic [63:0] bus_address;
        logic [31:0] doorbell_value;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [10:0] ring_entries;
        logic [7:0]  buffer_entries;
        logic [3:0]  align_log2;
        logic [31:0] buffer_doorbell_key;
        logic [31:0] ring_doorbell_key;
        logic [63:0] buffer_area_base;
    } t_cfg;

    typedef struct packed {
        logic vld0;
        logic vld1;
    } t_push;

    function automatic logic [7:0] next_buf(input logic [7:0] b, input logic [7:0] entries);
        logic [7:0] t;
        t = b + 8'd1;
        return (t >= entries) ? 8'd0 : t;
    endfunction

endpackage

// ===== rtl/rxrc_core.sv =====
module rxrc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  rxrc_pkg::t_item  i_item,
    input  rxrc_pkg::t_cfg   i_cfg,
    output rxrc_pkg::t_push  o_push,
    output rxrc_pkg::t_result o_res0,
    output rxrc_pkg::t_result o_res1
);
    import rxrc_pkg::*;

    logic [9:0]  r_ring_pos, n_ring_pos;
    logic        r_exp_gen, n_exp_gen;
    logic [7:0]  r_cons_buf, n_cons_buf;
    logic [7:0]  r_prod_buf, n_prod_buf;
    logic [13:0] r_fill_off, n_fill_off;
    logic [8:0]  r_pending, n_pending;
    logic [10:0] r_batch, n_batch;

    always_comb begin
        logic [10:0] ring_size;
        logic [10:0] pos_inc;
        logic        ring_wrap;
        logic [9:0]  adv_pos;
        logic        adv_gen;
        logic [7:0]  cand_buf;
        logic [13:0] cand_off;
        logic [14:0] fit_sum;
        logic        overrun;
        logic [3:0]  sh;
        logic [11:0] mask;
        logic [13:0] grow;
        logic [14:0] new_off;
        logic [20:0] pkt_local;
        logic [63:0] pkt_addr;
        logic [63:0] bufwr_addr;
        t_result     pkt;
        t_result     bufwr;
        t_result     ring_db;
        t_result     buf_db;

        n_ring_pos = r_ring_pos;
        n_exp_gen  = r_exp_gen;
        n_cons_buf = r_cons_buf;
        n_prod_buf = r_prod_buf;
        n_fill_off = r_fill_off;
        n_pending  = r_pending;
        n_batch    = r_batch;
        o_push     = '0;
        o_res0     = '0;
        o_res1     = '0;

        ring_size = (i_cfg.ring_entries > 11'(MAX_RING)) ? 11'(MAX_RING) : i_cfg.ring_entries;
        pos_inc   = {1'b0, r_ring_pos} + 11'd1;
        ring_wrap = (pos_inc >= ring_size);
        adv_pos   = ring_wrap ? 10'd0 : pos_inc[9:0];
        adv_gen   = r_exp_gen ^ ring_wrap;

        cand_buf = i_item.fresh_buffer ? next_buf(r_cons_buf, i_cfg.buffer_entries) : r_cons_buf;
        cand_off = i_item.fresh_buffer ? 14'd0 : r_fill_off;
        fit_sum  = {1'b0, cand_off} + {2'b00, i_item.payload_bytes};
        overrun  = (fit_sum > 15'(PAGE_BYTES));

        sh      = (i_cfg.align_log2 > 4'(ALIGN_MAX)) ? 4'(ALIGN_MAX) : i_cfg.align_log2;
        mask    = ~(12'hFFF << sh);
        grow    = ({1'b0, i_item.payload_bytes} + {2'b00, mask}) & ~{2'b00, mask};
        new_off = {1'b0, cand_off} + {1'b0, grow};

        pkt_local  = {1'b0, cand_buf, {PAGE_LOG2{1'b0}}} + {7'd0, cand_off} + 21'd2;
        pkt_addr   = i_cfg.buffer_area_base + {43'd0, pkt_local};
        bufwr_addr = i_cfg.buffer_area_base + {44'd0, r_prod_buf, {PAGE_LOG2{1'b0}}};

        pkt                = '0;
        pkt.result_kind    = RES_PACKET;
        pkt.entry_index    = cand_buf;
        pkt.byte_offset    = cand_off[12:0] + 13'd2;
        pkt.byte_count     = (i_item.payload_bytes >= 13'd2) ?
                             12'(i_item.payload_bytes - 13'd2) : 12'd0;
        pkt.bus_address    = pkt_addr;
        pkt.last           = 1'b1;

        bufwr              = '0;
        bufwr.result_kind  = RES_BUF_WRITE;
        bufwr.entry_index  = r_prod_buf;
        bufwr.bus_address  = bufwr_addr;

        ring_db                = '0;
        ring_db.result_kind    = RES_RING_DB;
        ring_db.doorbell_value = {21'd0, r_batch} | i_cfg.ring_doorbell_key;

        buf_db                 = '0;
        buf_db.result_kind     = RES_BUF_DB;
        buf_db.doorbell_value  = {26'd0, r_pending[8:3]} | i_cfg.buffer_doorbell_key;
        buf_db.last            = 1'b1;

        if (i_go) begin
            case (i_item.action)
                ACT_DESC: begin
                    o_push.vld0 = 1'b1;
                    o_res0.last = 1'b1;
                    if (i_item.desc_generation != r_exp_gen) begin
                        o_res0.result_kind = RES_NOT_READY;
                    end else if (i_item.desc_kind != DESC_BUF_PACKET) begin
                        o_res0.result_kind = RES_SKIPPED;
                        n_ring_pos = adv_pos;
                        n_exp_gen  = adv_gen;
                    end else if (overrun) begin
                        o_res0.result_kind = RES_OVERRUN;
                    end else begin
                        if (i_item.fresh_buffer) begin
                            o_res0      = bufwr;
                            o_res1      = pkt;
                            o_push.vld1 = 1'b1;
                            n_prod_buf  = next_buf(r_prod_buf, i_cfg.buffer_entries);
                            n_pending   = r_pending + 9'd1;
                        end else begin
                            o_res0 = pkt;
                        end
                        n_cons_buf = cand_buf;
                        n_fill_off = (new_off > {1'b0, FILL_MAX}) ? FILL_MAX : new_off[13:0];
                        n_batch    = (r_batch < BATCH_MAX) ? r_batch + 11'd1 : r_batch;
                        n_ring_pos = adv_pos;
                        n_exp_gen  = adv_gen;
                    end
                end
                ACT_BATCH: begin
                    if (r_batch != 11'd0) begin
                        n_batch     = 11'd0;
                        o_push.vld0 = 1'b1;
                        o_res0      = ring_db;
                        if (r_pending[8:3] != 6'd0) begin
                            n_pending   = {6'd0, r_pending[2:0]};
                            o_push.vld1 = 1'b1;
                            o_res1      = buf_db;
                        end else begin
                            o_res0.last = 1'b1;
                        end
                    end else if (r_pending[8:3] != 6'd0) begin
                        n_pending   = {6'd0, r_pending[2:0]};
                        o_push.vld0 = 1'b1;
                        o_res0      = buf_db;
                    end
                end
                ACT_RESTART: begin
                    n_ring_pos = 10'd0;
                    n_exp_gen  = 1'b1;
                    n_cons_buf = i_cfg.buffer_entries - 8'd1;
                    n_prod_buf = i_cfg.buffer_entries - 8'd8;
                    n_fill_off = 14'd0;
                    n_pending  = {6'd0, i_cfg.buffer_entries[2:0]};
                    n_batch    = 11'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_pos <= 10'd0;
            r_exp_gen  <= 1'b1;
            r_cons_buf <= RST_BUFFER_ENTRIES - 8'd1;
            r_prod_buf <= RST_BUFFER_ENTRIES - 8'd8;
            r_fill_off <= 14'd0;
            r_pending  <= {6'd0, RST_BUFFER_ENTRIES[2:0]};
            r_batch    <= 11'd0;
        end else begin
            r_ring_pos <= n_ring_pos;
            r_exp_gen  <= n_exp_gen;
            r_cons_buf <= n_cons_buf;
            r_prod_buf <= n_prod_buf;
            r_fill_off <= n_fill_off;
            r_pending  <= n_pending;
            r_batch    <= n_batch;
        end
    end

endmodule

// ===== rtl/rxrc_outq.sv =====
module rxrc_outq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rxrc_pkg::t_push                    i_push,
    input  rxrc_pkg::t_result                  i_res0,
    input  rxrc_pkg::t_result                  i_res1,
    input  logic                               i_stall,
    output logic                               o_valid,
    output rxrc_pkg::t_result                  o_data,
    output logic [rxrc_pkg::OUTQ_CNT_W-1:0]    o_level
);
    import rxrc_pkg::*;

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr, n_wr;
    logic [OUTQ_PTR_W-1:0]  r_rd, n_rd;
    logic [OUTQ_CNT_W-1:0]  r_cnt, n_cnt;
    logic                   pop;
    logic [OUTQ_CNT_W-1:0]  push_n;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_level = r_cnt;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        push_n = OUTQ_CNT_W'(i_push.vld0) + OUTQ_CNT_W'(i_push.vld1);
        n_wr   = r_wr + OUTQ_PTR_W'(push_n);
        n_rd   = pop ? r_rd + OUTQ_PTR_W'(1) : r_rd;
        n_cnt  = r_cnt + push_n - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.vld1) begin
            r_mem[r_wr + OUTQ_PTR_W'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/rx_ring_consumer_top.sv =====
// Receive descriptor ring consumer.
// Input channel (i_valid, i_data, o_stall) carries one word per descriptor,
// end-of-batch or restart command. Output channel (o_valid, o_data, i_stall)
// carries result words; the last word caused by an input has its last bit set.
// The user must write the registers through i_cfg_we, i_cfg_idx and i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// An accepted word is evaluated against the ring state while it sits in the
// input register; its result words are written into the result queue and shown from it.
// A new input word is taken every cycle as long as
// the four-entry result queue has room for two words.
// Words that cause one result sustain one word per cycle unless the receiver
// stalls; a word that causes two results pushes both into the queue at once.
// Restart, unknown commands and empty batches produce no result word.
// When the receiver stalls, the result queue fills and o_stall rises once
// fewer than two entries are free; results already queued are held in order.
// Synchronous reset loads the register defaults and the ring state that
// follows from them, and empties the input register and the queue.
module rx_ring_consumer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  rxrc_pkg::t_item                   i_data,
    output logic                              o_stall,
    output logic                              o_valid,
    output rxrc_pkg::t_result                 o_data,
    input  logic                              i_stall,
    input  logic                              i_cfg_we,
    input  logic [rxrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rxrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rxrc_pkg::*;

    t_cfg                  r_cfg;
    logic                  r_in_vld, n_in_vld;
    t_item                 r_in;
    logic                  go;
    logic                  accept;
    logic [OUTQ_CNT_W-1:0] level;
    t_push                 push;
    t_result               res0;
    t_result               res1;

    assign go      = r_in_vld && (level <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign o_stall = r_in_vld && !go;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (go) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_entries        <= RST_RING_ENTRIES;
            r_cfg.buffer_entries      <= RST_BUFFER_ENTRIES;
            r_cfg.align_log2          <= RST_ALIGN_LOG2;
            r_cfg.buffer_doorbell_key <= 32'd0;
            r_cfg.ring_doorbell_key   <= 32'd0;
            r_cfg.buffer_area_base    <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RING_ENTRIES:   r_cfg.ring_entries        <= i_cfg_data[10:0];
                REG_BUFFER_ENTRIES: r_cfg.buffer_entries      <= i_cfg_data[7:0];
                REG_ALIGN_LOG2:     r_cfg.align_log2          <= i_cfg_data[3:0];
                REG_BUF_DB_KEY:     r_cfg.buffer_doorbell_key <= i_cfg_data[31:0];
                REG_RING_DB_KEY:    r_cfg.ring_doorbell_key   <= i_cfg_data[31:0];
                REG_BUF_AREA_BASE:  r_cfg.buffer_area_base    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rxrc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    rxrc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_level (level)
    );

endmodule

// ===== rtl/rxrc_chk.sv =====
`include "rx_ring_consumer_top_macros.svh"

module rxrc_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input rxrc_pkg::t_result o_data,
    input logic              i_stall
);
    import rxrc_pkg::*;

    `RXRC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))
    `RXRC_ASSERT_NOW(a_bufwr_not_last, o_valid && (o_data.result_kind == RES_BUF_WRITE), !o_data.last)
    `RXRC_ASSERT_NEXT(a_bufwr_then_pkt, o_valid && !i_stall && (o_data.result_kind == RES_BUF_WRITE), o_valid && (o_data.result_kind == RES_PACKET) && o_data.last)
    `RXRC_ASSERT_NOW(a_pkt_pad, o_valid && (o_data.result_kind == RES_PACKET), o_data.byte_offset >= 13'd2)

endmodule

bind rx_ring_consumer_top rxrc_chk u_chk (.*);

// ===== test/tb_rx_ring_consumer_top.sv =====
module tb_rx_ring_consumer_top;
    import rxrc_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam t_cfg DEFAULT_CFG = '{
        ring_entries: RST_RING_ENTRIES,
        buffer_entries: RST_BUFFER_ENTRIES,
        align_log2: RST_ALIGN_LOG2,
        buffer_doorbell_key: 32'd0,
        ring_doorbell_key: 32'd0,
        buffer_area_base: 64'd0
    };

    typedef struct packed {
        logic [9:0]  ring_pos;
        logic        exp_gen;
        logic [7:0]  cons_buf;
        logic [7:0]  prod_buf;
        logic [13:0] fill;
        logic [8:0]  posts;
        logic [10:0] batch;
    } ring_state_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_item                 i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_result               o_data;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_item       descriptor_feed[$];
    t_result     ring_reports_due[$];
    t_cfg        cfg_shadow = DEFAULT_CFG;
    ring_state_t ring_now;
    ring_state_t ring_plan;
    bit          in_taken = 1'b0;
    bit          offering = 1'b0;
    bit          calm = 1'b0;
    int          hold_left = 0;
    int          bad_reports = 0;
    int          cycle_count = 0;

    rx_ring_consumer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic ring_state_t registered_state(input t_cfg c);
        ring_state_t s;
        s.ring_pos = '0;
        s.exp_gen  = 1'b1;
        s.cons_buf = c.buffer_entries - 8'd1;
        s.prod_buf = c.buffer_entries - 8'd8;
        s.fill     = '0;
        s.posts    = {6'd0, s.prod_buf[2:0]};
        s.batch    = '0;
        return s;
    endfunction

    function automatic logic [7:0] step_buffer(input logic [7:0] b, input logic [7:0] count);
        return (b == 8'hFF || b + 8'd1 >= count) ? 8'd0 : b + 8'd1;
    endfunction

    function automatic logic [63:0] page_address(input t_cfg c, input logic [7:0] b);
        return c.buffer_area_base + ({56'd0, b} << PAGE_LOG2);
    endfunction

    function automatic void advance_ring(inout ring_state_t s, input t_cfg c);
        logic [10:0] span;
        logic [10:0] nxt;
        span = (c.ring_entries > MAX_RING) ? 11'(MAX_RING) : c.ring_entries;
        nxt = {1'b0, s.ring_pos} + 11'd1;
        if (nxt >= span) begin
            s.ring_pos = '0;
            s.exp_gen  = !s.exp_gen;
        end else begin
            s.ring_pos = nxt[9:0];
        end
    endfunction

    function automatic int unsigned consume_word(inout ring_state_t s, input t_cfg c,
                                                 input t_item w, output t_result res [2]);
        int unsigned n;
        logic [7:0]  bufi;
        logic [31:0] off;
        logic [31:0] len;
        logic [31:0] mask;
        logic [3:0]  sh;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        case (w.action)
            ACT_DESC: begin
                bufi = s.cons_buf;
                off  = 32'(s.fill);
                len  = 32'(w.payload_bytes);
                if (w.desc_generation != s.exp_gen) begin
                    res[n].result_kind = RES_NOT_READY;
                    n++;
                end else if (w.desc_kind != DESC_BUF_PACKET) begin
                    advance_ring(s, c);
                    res[n].result_kind = RES_SKIPPED;
                    n++;
                end else begin
                    if (w.fresh_buffer) begin
                        bufi = step_buffer(bufi, c.buffer_entries);
                        off  = 0;
                    end
                    if (off + len > PAGE_BYTES) begin
                        res[n].result_kind = RES_OVERRUN;
                        n++;
                    end else begin
                        if (w.fresh_buffer) begin
                            res[n].result_kind = RES_BUF_WRITE;
                            res[n].entry_index = s.prod_buf;
                            res[n].bus_address = page_address(c, s.prod_buf);
                            n++;
                            s.prod_buf = step_buffer(s.prod_buf, c.buffer_entries);
                            s.posts    = s.posts + 9'd1;
                        end
                        s.cons_buf = bufi;
                        res[n].result_kind = RES_PACKET;
                        res[n].entry_index = bufi;
                        res[n].byte_offset = 13'(off + 32'd2);
                        res[n].byte_count  = (len >= 2) ? 12'(len - 32'd2) : 12'd0;
                        res[n].bus_address = page_address(c, bufi) + 64'(off) + 64'd2;
                        n++;
                        sh   = (c.align_log2 > ALIGN_MAX) ? 4'(ALIGN_MAX) : c.align_log2;
                        mask = (32'd1 << sh) - 32'd1;
                        off  = off + ((len + mask) & ~mask);
                        s.fill = (off > 32'(FILL_MAX)) ? FILL_MAX : off[13:0];
                        if (s.batch < BATCH_MAX) s.batch = s.batch + 11'd1;
                        advance_ring(s, c);
                    end
                end
            end
            ACT_BATCH: begin
                if (s.batch != 0) begin
                    res[n].result_kind    = RES_RING_DB;
                    res[n].doorbell_value = c.ring_doorbell_key | 32'(s.batch);
                    n++;
                    s.batch = '0;
                end
                if (s.posts >= 9'd8) begin
                    res[n].result_kind    = RES_BUF_DB;
                    res[n].doorbell_value = c.buffer_doorbell_key | 32'(s.posts >> 3);
                    n++;
                    s.posts = {6'd0, s.posts[2:0]};
                end
            end
            ACT_RESTART: begin
                s = registered_state(c);
            end
            default: begin
            end
        endcase
        if (n > 0) res[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic string report_text(input t_result r);
        return $sformatf("kind %0d index %0d offset %0d count %0d address %h doorbell %h last %0b",
                         r.result_kind, r.entry_index, r.byte_offset, r.byte_count,
                         r.bus_address, r.doorbell_value, r.last);
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (ring_reports_due.size() == 0) begin
            bad_reports++;
            if (bad_reports <= 10) $display("unexpected result word: %s", report_text(got));
        end else begin
            want = ring_reports_due.pop_front();
            if (got.result_kind !== want.result_kind || got.entry_index !== want.entry_index ||
                got.byte_offset !== want.byte_offset || got.byte_count !== want.byte_count ||
                got.bus_address !== want.bus_address ||
                got.doorbell_value !== want.doorbell_value || got.last !== want.last) begin
                bad_reports++;
                if (bad_reports <= 10) begin
                    $display("result mismatch: expected %s", report_text(want));
                    $display("                 got      %s", report_text(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result produced [2];
        int unsigned count;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (!i_rst_n) begin
            cfg_shadow = DEFAULT_CFG;
            ring_now   = registered_state(DEFAULT_CFG);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RING_ENTRIES:   cfg_shadow.ring_entries        = i_cfg_data[10:0];
                    REG_BUFFER_ENTRIES: cfg_shadow.buffer_entries      = i_cfg_data[7:0];
                    REG_ALIGN_LOG2:     cfg_shadow.align_log2          = i_cfg_data[3:0];
                    REG_BUF_DB_KEY:     cfg_shadow.buffer_doorbell_key = i_cfg_data[31:0];
                    REG_RING_DB_KEY:    cfg_shadow.ring_doorbell_key   = i_cfg_data[31:0];
                    REG_BUF_AREA_BASE:  cfg_shadow.buffer_area_base    = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_valid && !o_stall) begin
                in_taken = 1'b1;
                count = consume_word(ring_now, cfg_shadow, i_data, produced);
                for (int k = 0; k < count; k++) ring_reports_due.push_back(produced[k]);
            end
            if (o_valid && !i_stall) check_result(o_data);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                offering = 1'b0;
                descriptor_feed.delete(0);
            end
            if (!offering && descriptor_feed.size() != 0 && (calm || $urandom_range(99) >= 16))
                offering = 1'b1;
            i_valid <= offering;
            if (offering) i_data <= descriptor_feed[0];
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 16);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input logic [10:0] ring, input logic [7:0] bufs,
                                 input logic [3:0] align, input logic [31:0] buf_key,
                                 input logic [31:0] ring_key, input logic [63:0] base);
        write_reg(REG_RING_ENTRIES, 64'(ring));
        write_reg(REG_BUFFER_ENTRIES, 64'(bufs));
        write_reg(REG_ALIGN_LOG2, 64'(align));
        write_reg(REG_BUF_DB_KEY, 64'(buf_key));
        write_reg(REG_RING_DB_KEY, 64'(ring_key));
        write_reg(REG_BUF_AREA_BASE, base);
    endtask

    task automatic queue_word(input t_item w);
        t_result ignored [2];
        void'(consume_word(ring_plan, cfg_shadow, w, ignored));
        descriptor_feed.push_back(w);
    endtask

    task automatic desc_word(input bit gen_ok, input logic [1:0] kind, input bit fresh,
                             input logic [12:0] len);
        t_item w;
        w.action          = ACT_DESC;
        w.desc_generation = gen_ok ? ring_plan.exp_gen : !ring_plan.exp_gen;
        w.desc_kind       = kind;
        w.fresh_buffer    = fresh;
        w.payload_bytes   = len;
        queue_word(w);
    endtask

    task automatic control_word(input logic [1:0] act);
        t_item w;
        w = t_item'($urandom);
        w.action = act;
        queue_word(w);
    endtask

    task automatic random_word();
        int unsigned pick;
        int unsigned lsel;
        logic [12:0] len;
        logic [1:0]  kind;
        bit          fresh;
        pick = $urandom_range(99);
        if (pick < 2) begin
            control_word(ACT_UNKNOWN);
        end else if (pick < 4) begin
            control_word(ACT_RESTART);
        end else if (pick < 14) begin
            control_word(ACT_BATCH);
        end else begin
            lsel = $urandom_range(99);
            if (lsel < 55) len = 13'($urandom_range(1500));
            else if (lsel < 70) len = 13'($urandom_range(63));
            else if (lsel < 85) len = 13'($urandom_range(4096, 1500));
            else if (lsel < 93) len = 13'd4096;
            else len = 13'($urandom_range(8191, 4097));
            kind = ($urandom_range(99) < 90) ? DESC_BUF_PACKET : 2'($urandom_range(3, 1));
            if (32'(ring_plan.fill) + 32'(len) > PAGE_BYTES) fresh = $urandom_range(99) < 85;
            else fresh = $urandom_range(99) < 15;
            desc_word($urandom_range(99) >= 8, kind, fresh, len);
        end
    endtask

    task automatic random_phase(input int count);
        control_word(ACT_RESTART);
        repeat (count) random_word();
    endtask

    task automatic drain();
        while (descriptor_feed.size() != 0 || offering || ring_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        ring_plan = ring_now;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        ring_plan = ring_now;

        desc_word(1'b0, DESC_BUF_PACKET, 1'b0, 13'd64);
        desc_word(1'b1, 2'd1, 1'b0, 13'd0);
        desc_word(1'b1, 2'd2, 1'b1, 13'd8191);
        desc_word(1'b1, 2'd3, 1'b0, 13'd100);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b1, 13'd100);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b0, 13'd0);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b0, 13'd1);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b0, 13'd4096);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b1, 13'd8191);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b1, 13'd4096);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b0, 13'd1);
        control_word(ACT_BATCH);
        control_word(ACT_BATCH);
        control_word(ACT_UNKNOWN);
        control_word(ACT_RESTART);
        desc_word(1'b1, DESC_BUF_PACKET, 1'b0, 13'd4095);
        control_word(ACT_BATCH);
        drain();

        calm = 1'b1;
        set_registers(11'd8, 8'd16, 4'd0, $urandom, $urandom, {$urandom, $urandom});
        random_phase(100);
        drain();
        calm = 1'b0;

        set_registers(11'd1, 8'd255, 4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        random_phase(100);
        @(posedge i_clk);
        hold_left = 80;
        drain();

        set_registers(11'd0, 8'd17, 4'd15, 32'd0, 32'd0, {$urandom, $urandom});
        random_phase(50);
        drain();
        repeat (50) random_word();
        drain();

        set_registers(11'd2047, 8'd200, 4'd13, $urandom, $urandom, {$urandom, $urandom});
        random_phase(100);
        drain();

        set_registers(11'd1024, 8'd255, 4'd6, $urandom, $urandom, 64'd0);
        random_phase(100);
        drain();

        set_registers(11'd1023, 8'd16, 4'd3, $urandom, $urandom, {$urandom, $urandom});
        random_phase(100);
        drain();

        if (bad_reports == 0 && ring_reports_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rxrc_pkg.sv
rtl/rxrc_core.sv
rtl/rxrc_outq.sv
rtl/rx_ring_consumer_top.sv
rtl/rxrc_chk.sv
test/tb_rx_ring_consumer_top.sv
